/* src/afdc_pkg.sv */
// shared types and constants for the frame deframer with 8-bit checksum
// no dependencies; imported by afdc_parser and api_frame_deframer_checksum_top
`default_nettype none

package afdc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } phase_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CSUM_ERR = 2'd1;
    localparam logic [1:0] ST_IGNORED  = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic CFG_DELIM   = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [7:0]  DELIM_RESET   = 8'd126;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0]  CSUM_BASE     = 8'hFF;

    localparam int OUT_TDATA_W = 48;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [1:0]  status;
        logic [15:0] frame_length;
    } result_t;

    typedef struct packed {
        logic [7:0]  start_delimiter;
        logic [15:0] timeout_ticks;
    } cfg_t;

endpackage

`default_nettype wire

/* src/afdc_parser.sv */
// frame parser state machine: header, payload indexing, checksum and idle timeout
// depends on afdc_pkg
`default_nettype none

module afdc_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             command,
    input  wire logic [7:0]       rx_byte,
    input  afdc_pkg::cfg_t        cfg,
    output logic                  res_valid,
    output afdc_pkg::result_t     res
);
    import afdc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] idle_reg, idle_next;

    logic [15:0] idle_inc;
    logic [15:0] seen_inc;

    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign seen_inc = seen_reg + 16'd1;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (command == CMD_BYTE)
        begin
            unique case (phase_reg)
                PH_IDLE:    phase_next = (rx_byte == cfg.start_delimiter) ? PH_LEN_HI : PH_IDLE;
                PH_LEN_HI:  phase_next = PH_LEN_LO;
                PH_LEN_LO:  phase_next = ({len_reg[15:8], rx_byte} == 16'd0) ? PH_CHECK
                                                                              : PH_PAYLOAD;
                PH_PAYLOAD: phase_next = (seen_inc >= len_reg) ? PH_CHECK : PH_PAYLOAD;
                PH_CHECK:   phase_next = PH_IDLE;
                default:    phase_next = PH_IDLE;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        len_next  = len_reg;
        seen_next = seen_reg;
        sum_next  = sum_reg;
        idle_next = idle_reg;
        res_valid = 1'b0;
        res       = '0;
        if (command == CMD_TICK)
        begin
            if (phase_reg == PH_IDLE)
            begin
                idle_next = idle_inc;
                if (idle_inc >= cfg.timeout_ticks)
                begin
                    idle_next  = '0;
                    res_valid  = 1'b1;
                    res.kind   = KIND_STATUS;
                    res.status = ST_TIMEOUT;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    idle_next = '0;
                    if (rx_byte != cfg.start_delimiter)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_STATUS;
                        res.status = ST_IGNORED;
                    end
                end
                PH_LEN_HI:
                    len_next = {rx_byte, 8'd0};
                PH_LEN_LO:
                begin
                    len_next  = {len_reg[15:8], rx_byte};
                    seen_next = '0;
                    sum_next  = '0;
                end
                PH_PAYLOAD:
                begin
                    sum_next         = sum_reg + rx_byte;
                    seen_next        = seen_inc;
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = rx_byte;
                    res.byte_index   = seen_reg;
                end
                PH_CHECK:
                begin
                    idle_next        = '0;
                    res_valid        = 1'b1;
                    res.kind         = KIND_STATUS;
                    res.status       = ((CSUM_BASE - sum_reg) == rx_byte) ? ST_OK : ST_CSUM_ERR;
                    res.frame_length = len_reg;
                end
                default:
                    idle_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            len_reg   <= '0;
            seen_reg  <= '0;
            sum_reg   <= '0;
            idle_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            sum_reg   <= sum_next;
            idle_reg  <= idle_next;
        end
    end

    // a frame always closes back to idle after its checksum byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && command == CMD_BYTE && phase_reg == PH_CHECK) |=> (phase_reg == PH_IDLE))
        else $error("frame did not close after checksum byte");

    // ticks never disturb an open frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && command == CMD_TICK && phase_reg != PH_IDLE) |=> $stable(phase_reg))
        else $error("tick changed phase inside a frame");

    // payload index stays below the declared length
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_PAYLOAD) |-> (res.byte_index < len_reg))
        else $error("payload index beyond declared length");

    // the idle counter only runs while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |=> (idle_reg == $past(idle_reg) || phase_reg == PH_IDLE))
        else $error("idle counter moved inside a frame");

endmodule

`default_nettype wire

/* src/api_frame_deframer_checksum_top.sv */
// top level of the frame deframer: stream ports, configuration registers, result register
// depends on afdc_pkg and afdc_parser
`default_nettype none

// Deframes a serial byte stream: a start delimiter, a 16-bit big-endian length,
// that many payload bytes (each sent out at once with its index), then a checksum
// byte checked against 0xFF minus the 8-bit payload sum. Every input transfer is
// either a byte (tuser 0) or a time tick (tuser 1) and gives at most one result
// transfer; idle ticks give a timeout status every timeout_ticks ticks. One input
// transfer is taken per cycle while the output side takes results: each transfer
// passes an input register and the parser logic into the result register.
// Register 0 is the start delimiter (reset 126), register 1 the timeout (reset 1000).
module api_frame_deframer_checksum_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                             s_axis_tuser,  // [0] command
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [7:0] payload_byte, [23:8] byte_index, [25:24] status, [41:26] frame_length,
    // [47:42] zero
    output logic [afdc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tuser,  // [0] kind
    // configuration writes
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [15:0]                      cfg_data
);
    import afdc_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        proceed;
    logic        res_valid;
    result_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delimiter <= DELIM_RESET;
            cfg_reg.timeout_ticks   <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DELIM:   cfg_reg.start_delimiter <= cfg_data[7:0];
                CFG_TIMEOUT: cfg_reg.timeout_ticks   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // the held input moves on once the result slot is free or being emptied
    assign proceed       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proceed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    afdc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (proceed),
        .command   (in_cmd_reg),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proceed)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {6'd0, out_reg.frame_length, out_reg.status,
                            out_reg.byte_index, out_reg.payload_byte};

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !proceed)
        else $error("result overwritten while stalled");

    // a held input is only released into the parser
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proceed) |=> in_valid_reg)
        else $error("held input lost");

    // payload results carry no status or length
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_PAYLOAD)
            |-> (out_reg.status == ST_OK && out_reg.frame_length == 16'd0))
        else $error("payload result with status fields set");

endmodule

`default_nettype wire
